@@ rtl/kslu_pkg.sv @@
// kslu_pkg: shared types, constants and helper functions of the k-mer lookup unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package kslu_pkg;

	localparam int KMER_MAX   = 32;
	localparam int REF_DEPTH  = 4096;
	localparam int REF_AW     = 12;
	localparam int REF_LW     = 13;
	localparam int KW         = 6;
	localparam int COUNT_W    = 14;
	localparam int CMD_DEPTH  = 4;
	localparam int CMD_PW     = 2;
	localparam int OUT_DEPTH  = 2;
	localparam int OUT_PW     = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 14'd16383;
	localparam logic [KW-1:0]      KMER_RESET = 6'd16;
	localparam logic [KW-1:0]      KMER_TOP   = 6'd32;

	// input kind codes
	localparam logic [1:0] KIND_REF   = 2'd0;
	localparam logic [1:0] KIND_BOTH  = 2'd1;
	localparam logic [1:0] KIND_FWD   = 2'd2;
	localparam logic [1:0] KIND_FETCH = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] base_char;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic               word_ok;
		logic [COUNT_W-1:0] hit_count;
		logic               hit_valid;
		logic [REF_AW-1:0]  hit_position;
		logic               hit_reverse;
		logic               last_hit;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_REF,
		OP_QCHAR,
		OP_FETCH
	} op_t;

	// classified request handed from front to engine
	typedef struct packed {
		op_t        op;
		logic [2:0] base;
		logic       last;
		logic       both;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RC,
		ST_COUNT,
		ST_FETCH
	} state_t;

	// valid bit and 2-bit code of an ascii base
	function automatic logic [2:0] decode_base(input logic [7:0] ch);
		logic [2:0] r;
		case (ch)
			8'h41, 8'h61: r = 3'd4;
			8'h43, 8'h63: r = 3'd5;
			8'h47, 8'h67: r = 3'd6;
			8'h54, 8'h74: r = 3'd7;
			default:      r = 3'd0;
		endcase
		return r;
	endfunction

	// reverse complement of a k-base word (k in 1..32)
	function automatic logic [63:0] rev_comp(input logic [63:0] code, input logic [KW-1:0] k);
		logic [63:0] full;
		logic [6:0]  sh;
		for (int i = 0; i < KMER_MAX; i++) begin
			full[2*i +: 2] = 2'd3 - code[2*(KMER_MAX-1-i) +: 2];
		end
		sh = 7'd64 - {k, 1'b0};
		return full >> sh;
	endfunction

endpackage
`default_nettype wire

@@ rtl/kslu_front.sv @@
// kslu_front: accepts input requests, classifies them and queues them for the engine
// depends on kslu_pkg
`timescale 1ns / 1ps
`default_nettype none
module kslu_front (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic push,
	output logic               full,
	input  kslu_pkg::in_item_t item,
	output logic               cmd_valid,
	output kslu_pkg::cmd_t     cmd,
	input  wire                logic cmd_pop
);

	kslu_pkg::cmd_t                 fifo_q [kslu_pkg::CMD_DEPTH];
	logic [kslu_pkg::CMD_PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [kslu_pkg::CMD_PW:0]      cnt_q;
	kslu_pkg::cmd_t                 cls;
	logic                           do_push, do_pop;

	// classify the request
	always_comb begin
		cls.base = kslu_pkg::decode_base(item.base_char);
		cls.last = item.last_char;
		cls.both = (item.kind == kslu_pkg::KIND_BOTH);
		case (item.kind)
			kslu_pkg::KIND_REF:   cls.op = kslu_pkg::OP_REF;
			kslu_pkg::KIND_FETCH: cls.op = kslu_pkg::OP_FETCH;
			default:              cls.op = kslu_pkg::OP_QCHAR;
		endcase
	end

	assign full      = (cnt_q == (kslu_pkg::CMD_PW+1)'(kslu_pkg::CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/kslu_outq.sv @@
// kslu_outq: small result queue between the engine and the result port
// depends on kslu_pkg
`timescale 1ns / 1ps
`default_nettype none
module kslu_outq (
	input  wire                 logic clk,
	input  wire                 logic arst_n,
	input  wire                 logic res_valid,
	input  kslu_pkg::out_item_t res,
	output logic                space,
	output logic                empty,
	input  wire                 logic pop,
	output kslu_pkg::out_item_t result
);

	kslu_pkg::out_item_t           fifo_q [kslu_pkg::OUT_DEPTH];
	logic [kslu_pkg::OUT_PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [kslu_pkg::OUT_PW:0]     cnt_q;
	logic                          do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign space   = (cnt_q != (kslu_pkg::OUT_PW+1)'(kslu_pkg::OUT_DEPTH));
	assign result  = fifo_q[rd_ptr_q];
	assign do_push = res_valid && space;
	assign do_pop  = pop && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/kslu_engine.sv @@
// kslu_engine: reference store, query assembly, match counting and hit fetch scans
// depends on kslu_pkg
`timescale 1ns / 1ps
`default_nettype none
module kslu_engine (
	input  wire                 logic clk,
	input  wire                 logic arst_n,
	input  wire                 logic cmd_valid,
	input  kslu_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  wire                 logic out_space,
	input  wire                 logic [kslu_pkg::KW-1:0] kmer_len,
	output logic                res_valid,
	output kslu_pkg::out_item_t res
);

	kslu_pkg::state_t state_q, state_d;

	logic [2:0]                     mem [kslu_pkg::REF_DEPTH];
	logic [kslu_pkg::REF_LW-1:0]    ref_len_q;
	logic                           ref_closed_q;
	logic [63:0]                    q_code_q;
	logic [kslu_pkg::KW-1:0]        q_len_q;
	logic                           q_bad_q;
	logic [kslu_pkg::KW-1:0]        word_k_q;
	logic [63:0]                    fwd_key_q, rev_key_q, mask_q;
	logic                           rev_en_q, both_q;
	logic [kslu_pkg::COUNT_W-1:0]   hits_left_q, count_q;
	logic [kslu_pkg::REF_LW-1:0]    scan_ptr_q, rd_ptr_q;
	logic                           phase_q;
	logic                           rd_vld_s1;
	logic [kslu_pkg::REF_AW-1:0]    rd_pos_s1;
	logic [2:0]                     rd_data_s1;
	logic [63:0]                    win_q;
	logic [kslu_pkg::KW-1:0]        run_q;

	logic                           take, b_ok, word_ok, rd_en, mem_we;
	logic [63:0]                    nq_code, win_new, rc_val;
	logic [kslu_pkg::KW-1:0]        nq_len, run_new;
	logic                           nq_bad, full_win, fwd_m, rev_m, tgt_m;
	logic                           scan_end, pipe_done;
	logic [kslu_pkg::REF_LW-1:0]    hit_start, wr_addr;

	// query character and word check
	assign take    = (state_q == kslu_pkg::ST_IDLE) && cmd_valid && out_space;
	assign b_ok    = cmd.base[2] && (q_len_q < kslu_pkg::KMER_TOP);
	assign nq_code = b_ok ? {q_code_q[61:0], cmd.base[1:0]} : q_code_q;
	assign nq_len  = b_ok ? q_len_q + 1'b1 : q_len_q;
	assign nq_bad  = q_bad_q || !b_ok;
	assign word_ok = !nq_bad && (kmer_len != '0) && (kmer_len <= kslu_pkg::KMER_TOP)
		&& (nq_len == kmer_len);

	// sliding window over the read stream
	assign win_new  = {win_q[61:0], rd_data_s1[1:0]};
	assign run_new  = rd_data_s1[2] ? ((run_q == kslu_pkg::KMER_TOP) ? run_q : run_q + 1'b1)
		: '0;
	assign full_win = rd_vld_s1 && (run_new >= word_k_q);
	assign fwd_m    = full_win && ((win_new & mask_q) == fwd_key_q);
	assign rev_m    = full_win && rev_en_q && ((win_new & mask_q) == rev_key_q);
	assign tgt_m    = (state_q == kslu_pkg::ST_FETCH) && (phase_q ? rev_m : fwd_m);
	assign hit_start = kslu_pkg::REF_LW'(rd_pos_s1) + 1'b1 - kslu_pkg::REF_LW'(word_k_q);
	assign scan_end  = (rd_ptr_q >= ref_len_q);
	assign pipe_done = scan_end && !rd_vld_s1;
	assign rc_val    = kslu_pkg::rev_comp(fwd_key_q, word_k_q);

	// reference write address
	assign wr_addr = ref_closed_q ? '0 : ref_len_q;
	assign mem_we  = take && (cmd.op == kslu_pkg::OP_REF)
		&& (wr_addr < kslu_pkg::REF_LW'(kslu_pkg::REF_DEPTH));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kslu_pkg::ST_IDLE: begin
				if (take) begin
					if (cmd.op == kslu_pkg::OP_QCHAR && cmd.last && word_ok)
						state_d = kslu_pkg::ST_RC;
					else if (cmd.op == kslu_pkg::OP_FETCH && hits_left_q != '0)
						state_d = kslu_pkg::ST_FETCH;
				end
			end
			kslu_pkg::ST_RC: state_d = kslu_pkg::ST_COUNT;
			kslu_pkg::ST_COUNT: begin
				if (pipe_done) state_d = kslu_pkg::ST_IDLE;
			end
			kslu_pkg::ST_FETCH: begin
				if (tgt_m) state_d = kslu_pkg::ST_IDLE;
				else if (pipe_done && !(!phase_q && rev_en_q)) state_d = kslu_pkg::ST_IDLE;
			end
			default: state_d = kslu_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop   = take;
		res_valid = 1'b0;
		res       = '0;
		rd_en     = 1'b0;
		case (state_q)
			kslu_pkg::ST_IDLE: begin
				if (take && cmd.op == kslu_pkg::OP_QCHAR && cmd.last && !word_ok)
					res_valid = 1'b1;
				if (take && cmd.op == kslu_pkg::OP_FETCH && hits_left_q == '0)
					res_valid = 1'b1;
			end
			kslu_pkg::ST_COUNT: begin
				rd_en = !scan_end;
				if (pipe_done) begin
					res_valid     = 1'b1;
					res.word_ok   = 1'b1;
					res.hit_count = count_q;
				end
			end
			kslu_pkg::ST_FETCH: begin
				rd_en = !scan_end && !tgt_m;
				if (tgt_m) begin
					res_valid        = 1'b1;
					res.hit_valid    = 1'b1;
					res.hit_position = hit_start[kslu_pkg::REF_AW-1:0];
					res.hit_reverse  = phase_q;
					res.last_hit     = (hits_left_q == kslu_pkg::COUNT_W'(1));
				end else if (pipe_done && !(!phase_q && rev_en_q)) begin
					res_valid = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// reference memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr[kslu_pkg::REF_AW-1:0]] <= cmd.base;
		if (rd_en) begin
			rd_data_s1 <= mem[rd_ptr_q[kslu_pkg::REF_AW-1:0]];
			rd_pos_s1  <= rd_ptr_q[kslu_pkg::REF_AW-1:0];
		end
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kslu_pkg::ST_IDLE;
			ref_len_q    <= '0;
			ref_closed_q <= 1'b0;
			q_code_q     <= '0;
			q_len_q      <= '0;
			q_bad_q      <= 1'b0;
			word_k_q     <= '0;
			fwd_key_q    <= '0;
			rev_key_q    <= '0;
			mask_q       <= '0;
			rev_en_q     <= 1'b0;
			both_q       <= 1'b0;
			hits_left_q  <= '0;
			count_q      <= '0;
			scan_ptr_q   <= '0;
			rd_ptr_q     <= '0;
			phase_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			win_q        <= '0;
			run_q        <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (rd_vld_s1) begin
				win_q <= win_new;
				run_q <= run_new;
			end
			case (state_q)
				kslu_pkg::ST_IDLE: begin
					if (take) begin
						case (cmd.op)
							kslu_pkg::OP_REF: begin
								hits_left_q  <= '0;
								ref_closed_q <= cmd.last;
								if (wr_addr < kslu_pkg::REF_LW'(kslu_pkg::REF_DEPTH))
									ref_len_q <= wr_addr + 1'b1;
								else
									ref_len_q <= wr_addr;
							end
							kslu_pkg::OP_QCHAR: begin
								if (!cmd.last) begin
									q_code_q <= nq_code;
									q_len_q  <= nq_len;
									q_bad_q  <= nq_bad;
								end else begin
									q_code_q    <= '0;
									q_len_q     <= '0;
									q_bad_q     <= 1'b0;
									word_k_q    <= kmer_len;
									fwd_key_q   <= nq_code;
									mask_q      <= ~(64'hFFFF_FFFF_FFFF_FFFF << {kmer_len, 1'b0});
									both_q      <= cmd.both;
									rev_en_q    <= 1'b0;
									rev_key_q   <= '0;
									hits_left_q <= '0;
									scan_ptr_q  <= '0;
									phase_q     <= 1'b0;
								end
							end
							kslu_pkg::OP_FETCH: begin
								if (hits_left_q != '0) begin
									rd_ptr_q <= scan_ptr_q;
									run_q    <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				kslu_pkg::ST_RC: begin
					rev_key_q <= rc_val;
					rev_en_q  <= both_q && (rc_val != fwd_key_q);
					rd_ptr_q  <= '0;
					run_q     <= '0;
					count_q   <= '0;
				end
				kslu_pkg::ST_COUNT: begin
					if ((fwd_m || rev_m) && count_q != kslu_pkg::COUNT_MAX)
						count_q <= count_q + 1'b1;
					if (pipe_done) begin
						hits_left_q <= count_q;
						scan_ptr_q  <= '0;
						phase_q     <= 1'b0;
					end
				end
				kslu_pkg::ST_FETCH: begin
					if (tgt_m) begin
						hits_left_q <= hits_left_q - 1'b1;
						scan_ptr_q  <= hit_start + 1'b1;
					end else if (pipe_done) begin
						if (!phase_q && rev_en_q) begin
							phase_q    <= 1'b1;
							rd_ptr_q   <= '0;
							run_q      <= '0;
							scan_ptr_q <= '0;
						end else begin
							hits_left_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// a read in flight only while scanning
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == kslu_pkg::ST_COUNT || state_q == kslu_pkg::ST_FETCH
			|| state_q == kslu_pkg::ST_IDLE && $past(state_q) == kslu_pkg::ST_COUNT))
		else $error("read data outside a scan");

	// hit list never exceeds both strands of a full reference
	assert property (@(posedge clk) disable iff (!arst_n)
		hits_left_q <= kslu_pkg::COUNT_W'(2 * kslu_pkg::REF_DEPTH))
		else $error("hit list too long");

	// a result is only produced with room in the result queue
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_space)
		else $error("result without queue space");

endmodule
`default_nettype wire

@@ rtl/kmer_strand_index_lookup_unit.sv @@
// kmer_strand_index_lookup_unit: top level, configuration register and module wiring
// depends on kslu_pkg, kslu_front, kslu_engine, kslu_outq
`timescale 1ns / 1ps
`default_nettype none
// K-mer lookup over a streamed reference of up to 4096 bases. Requests enter through a
// 4-deep queue; the engine takes a reference or query character whenever it is idle and
// the result queue has room. The last character of a good query word starts a counting
// scan that reads the reference store one base per cycle through its single read port;
// one pass covers both strands, and a failed word gets its result without a scan.
// A fetch re-reads the store from one past the start of the previous hit to the next
// hit, or scans through up to two full passes when the list runs dry. Results wait in
// a 2-deep queue. kmer_length (1..32, reset 16) is written over the cfg channel, which
// is always ready, and must only change while idle.
module kmer_strand_index_lookup_unit (
	input  wire                 logic clk,
	input  wire                 logic arst_n,
	input  wire                 logic push,
	output logic                full,
	input  kslu_pkg::in_item_t  item,
	output logic                empty,
	input  wire                 logic pop,
	output kslu_pkg::out_item_t result,
	input  wire                 logic cfg_valid,
	output logic                cfg_ready,
	input  wire                 logic [kslu_pkg::KW-1:0] cfg_data
);

	logic [kslu_pkg::KW-1:0] kmer_len_q;
	logic                    cmd_valid, cmd_pop, out_space, res_valid;
	kslu_pkg::cmd_t          cmd;
	kslu_pkg::out_item_t     res;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q <= kslu_pkg::KMER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			kmer_len_q <= cfg_data;
		end
	end

	kslu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	kslu_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_space (out_space),
		.kmer_len  (kmer_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	kslu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.space     (out_space),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire

@@ tb/kmer_strand_index_lookup_unit_checker.sv @@
// kmer_strand_index_lookup_unit_checker: request/result monitor with its own lookup predictor
// depends on kslu_pkg; watches the request, result and cfg channels of the lookup unit
`timescale 1ns / 1ps
module kmer_strand_index_lookup_unit_checker (
	input  logic                clk,
	input  logic                push,
	input  logic                full,
	input  kslu_pkg::in_item_t  item,
	input  logic                empty,
	input  logic                pop,
	input  kslu_pkg::out_item_t result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [5:0]          cfg_data,
	output int                  fail_count,
	output int                  pending
);
	import kslu_pkg::*;

	// predictor state, reset values
	logic [2:0]  ref_mem [REF_DEPTH];
	int          ref_len = 0;
	bit          ref_closed = 0;
	logic [63:0] word_code = '0;
	int          word_len = 0;
	bit          word_bad = 0;
	int          scan_ptr = 0;
	int          scan_rev = 0;
	int          hits_left = 0;
	int          list_k = 0;
	logic [63:0] fwd_key = '0;
	logic [63:0] rev_key = '0;
	bit          rev_on = 0;
	int          kmer_len = 16;

	out_item_t expected_results [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [2:0] base_code(input logic [7:0] ch);
		case (ch)
			"A", "a": return 3'd4;
			"C", "c": return 3'd5;
			"G", "g": return 3'd6;
			"T", "t": return 3'd7;
			default:  return 3'd0;
		endcase
	endfunction

	function automatic logic [63:0] revcomp(input logic [63:0] code, input int k);
		logic [63:0] r = '0;
		for (int i = 0; i < k; i++) begin
			r = {r[61:0], 2'd3 - code[1:0]};
			code = code >> 2;
		end
		return r;
	endfunction

	function automatic bit window_hit(input int p, input int k, input logic [63:0] key);
		logic [63:0] c = '0;
		if (k < 1 || k > KMER_MAX || p + k > ref_len)
			return 0;
		for (int i = 0; i < k; i++) begin
			if (!ref_mem[p+i][2])
				return 0;
			c = {c[61:0], ref_mem[p+i][1:0]};
		end
		return c == key;
	endfunction

	function automatic int count_hits(input int k, input logic [63:0] key);
		int n = 0;
		for (int p = 0; p + k <= ref_len; p++)
			if (window_hit(p, k, key) && n < COUNT_MAX)
				n++;
		return n;
	endfunction

	// update the predicted state for one request and queue its result, if any
	task automatic predict_request(input in_item_t it);
		logic [2:0]  code;
		out_item_t   r;
		bit          ok;
		bit          found;
		int          total;
		int          p;
		logic [63:0] target;
		code = base_code(it.base_char);
		r = '0;
		case (it.kind)
			KIND_REF: begin
				if (ref_closed) begin
					ref_len = 0;
					ref_closed = 0;
				end
				hits_left = 0;
				if (ref_len < REF_DEPTH) begin
					ref_mem[ref_len] = code;
					ref_len++;
				end
				if (it.last_char)
					ref_closed = 1;
			end
			KIND_BOTH, KIND_FWD: begin
				if (!code[2] || word_len >= KMER_MAX) begin
					word_bad = 1;
				end else begin
					word_code = {word_code[61:0], code[1:0]};
					word_len++;
				end
				if (it.last_char) begin
					ok = !word_bad && kmer_len >= 1 && kmer_len <= KMER_MAX
						&& word_len == kmer_len;
					total = 0;
					list_k = kmer_len;
					fwd_key = word_code;
					rev_on = 0;
					rev_key = '0;
					if (ok) begin
						total = count_hits(kmer_len, word_code);
						if (it.kind == KIND_BOTH) begin
							rev_key = revcomp(word_code, kmer_len);
							if (rev_key != word_code) begin
								rev_on = 1;
								total += count_hits(kmer_len, rev_key);
								if (total > COUNT_MAX)
									total = COUNT_MAX;
							end
						end
					end
					hits_left = total;
					scan_ptr = 0;
					scan_rev = 0;
					word_code = '0;
					word_len = 0;
					word_bad = 0;
					r.word_ok = ok;
					r.hit_count = COUNT_W'(total);
					expected_results = {expected_results, r};
				end
			end
			default: begin
				// fetch: walk forward windows, then reverse ones
				found = 0;
				if (hits_left != 0) begin
					while (!found && scan_rev <= 1) begin
						if (scan_rev == 1 && !rev_on)
							break;
						target = scan_rev ? rev_key : fwd_key;
						while (!found && scan_ptr + list_k <= ref_len) begin
							p = scan_ptr;
							scan_ptr++;
							if (window_hit(p, list_k, target)) begin
								found = 1;
								hits_left--;
								r.hit_valid = 1;
								r.hit_position = REF_AW'(p);
								r.hit_reverse = scan_rev[0];
								r.last_hit = hits_left == 0;
							end
						end
						if (!found) begin
							scan_rev++;
							scan_ptr = 0;
						end
					end
					if (!found)
						hits_left = 0;
				end
				expected_results = {expected_results, r};
			end
		endcase
	endtask

	// sample all channels at the rising edge
	always @(posedge clk) begin
		out_item_t exp_r;
		if (pop && !empty) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result %p", result);
			end else begin
				exp_r = expected_results.pop_front();
				if (result.word_ok !== exp_r.word_ok || result.hit_count !== exp_r.hit_count
					|| result.hit_valid !== exp_r.hit_valid
					|| result.hit_position !== exp_r.hit_position
					|| result.hit_reverse !== exp_r.hit_reverse
					|| result.last_hit !== exp_r.last_hit) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected %p actual %p", exp_r, result);
				end
			end
		end
		if (cfg_valid && cfg_ready)
			kmer_len = cfg_data;
		if (push && !full)
			predict_request(item);
		pending = expected_results.size();
	end

endmodule

@@ tb/kmer_strand_index_lookup_unit_tb.sv @@
// kmer_strand_index_lookup_unit_tb: stimulus and verdict for the k-mer lookup unit
// depends on kslu_pkg, kmer_strand_index_lookup_unit and kmer_strand_index_lookup_unit_checker
`timescale 1ns / 1ps
module kmer_strand_index_lookup_unit_tb;
	import kslu_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    item;
	logic        empty;
	logic        pop;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;
	int          fail_count;
	int          pending;

	int          send_idle_pct = 0;
	int          pop_stall_pct = 0;
	int          requests_sent = 0;
	int          cur_k = 16;
	logic [7:0]  ref_chars [$];

	kmer_strand_index_lookup_unit DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	kmer_strand_index_lookup_unit_checker u_checker (
		.clk(clk), .push(push), .full(full), .item(item), .empty(empty), .pop(pop),
		.result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("*** FAILED ***");
		$finish;
	end

	// result side stalls
	always @(negedge clk) begin
		pop = ($urandom_range(99) >= pop_stall_pct);
	end

	// one request, with a random gap ahead of it
	task automatic send(input logic [1:0] kind, input logic [7:0] ch, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			push = 0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item.kind = kind;
		item.base_char = ch;
		item.last_char = last;
		push = 1;
		while (full) @(negedge clk);
		@(negedge clk);
		requests_sent++;
	endtask

	// wait for all results plus engine latency, then write kmer_length
	task automatic set_k(input int v);
		push = 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_data = 6'(v);
		cfg_valid = 1;
		while (!cfg_ready) @(negedge clk);
		@(negedge clk);
		cfg_valid = 0;
		cur_k = v;
	endtask

	function automatic logic [7:0] rand_base();
		int r = $urandom_range(99);
		if (r < 4)
			return 8'($urandom_range(255));
		if (r < 8)
			return "N";
		case ($urandom_range(7))
			0: return "A";
			1: return "C";
			2: return "G";
			3: return "T";
			4: return "a";
			5: return "c";
			6: return "g";
			default: return "t";
		endcase
	endfunction

	task automatic send_string(input logic [1:0] kind, input string s);
		for (int i = 0; i < s.len(); i++)
			send(kind, s[i], i == s.len() - 1);
	endtask

	task automatic send_reference(input int len);
		ref_chars.delete();
		for (int i = 0; i < len; i++) begin
			ref_chars = {ref_chars, rand_base()};
			send(KIND_REF, ref_chars[i], i == len - 1);
		end
	endtask

	// query word: mostly a window of the reference, sometimes damaged
	task automatic send_word();
		int          len;
		int          pos;
		int          r;
		logic [1:0]  kind;
		logic [7:0]  ch;
		r = $urandom_range(99);
		len = (cur_k >= 1 && cur_k <= 32) ? cur_k : $urandom_range(1, 32);
		if (r < 8)
			len = $urandom_range(1, 36);
		kind = $urandom_range(1) ? KIND_BOTH : KIND_FWD;
		pos = (ref_chars.size() > len) ? $urandom_range(ref_chars.size() - len) : 0;
		for (int i = 0; i < len; i++) begin
			ch = (pos + i < ref_chars.size() && r >= 15) ? ref_chars[pos+i] : rand_base();
			if ($urandom_range(99) < 2)
				ch = 8'($urandom_range(255));
			if ($urandom_range(99) < 5)
				kind = $urandom_range(1) ? KIND_BOTH : KIND_FWD;
			send(kind, ch, i == len - 1);
		end
	endtask

	initial begin
		int kv;
		push = 0;
		cfg_valid = 0;
		cfg_data = '0;
		item = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: small reference with an invalid base, both strands, bad word, mixed kinds
		set_k(3);
		send_string(KIND_REF, "ACGTNCGT");
		send_string(KIND_BOTH, "ACG");
		repeat (4) send(KIND_FETCH, 8'hff, 1);
		send_string(KIND_FWD, "AXG");
		send(KIND_BOTH, "C", 0);
		send(KIND_BOTH, "g", 0);
		send(KIND_FWD, "T", 1);
		send(KIND_FETCH, 8'h00, 0);

		// random sessions, each with its own register value, reference and idling mode
		for (int s = 0; requests_sent < 1550; s++) begin
			case (s % 4)
				0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
				1: begin send_idle_pct = 82; pop_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  pop_stall_pct = 82; end
				default: begin send_idle_pct = 6; pop_stall_pct = 6; end
			endcase
			case (s % 9)
				0: kv = 1;
				1: kv = 32;
				2: kv = $urandom_range(99) < 50 ? 0 : $urandom_range(33, 63);
				default: kv = $urandom_range(1, 10);
			endcase
			if (s == 5)
				kv = 12;
			set_k(kv);
			if (s == 5) begin
				send_idle_pct = 0;
				send_reference(200);
			end else begin
				send_reference($urandom_range(4, 100));
			end
			for (int q = 0; q < (s == 5 ? 2 : 6); q++) begin
				send_word();
				for (int f = $urandom_range(0, 8); f > 0; f--)
					send(KIND_FETCH, 8'($urandom_range(255)), 1'($urandom_range(1)));
				if ($urandom_range(99) < 5)
					send(KIND_REF, rand_base(), 1'($urandom_range(1)));
			end
		end

		push = 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/kslu_pkg.sv
rtl/kslu_front.sv
rtl/kslu_outq.sv
rtl/kslu_engine.sv
rtl/kmer_strand_index_lookup_unit.sv
tb/kmer_strand_index_lookup_unit_checker.sv
tb/kmer_strand_index_lookup_unit_tb.sv
